// ----- design/http_chunked_body_decoder_core_defines.svh -----
// Assertion macros for the chunked body decoder.
// Assumes clk_i and rst_ni in the scope of use; empty bodies under SYNTHESIS.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HCBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcbd assertion failed");
`define HCBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT_IMP(lbl, ante, cons)
`define HCBD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- design/hcbd_pkg.sv -----
// Types, character codes and hex digit decode for the chunked body decoder.
// No dependencies.
package hcbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_SIZE_CR,
    PH_DATA,
    PH_TAIL,
    PH_TAIL_CR
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   done;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       carries_data;
    logic       body_end;
    logic       end_kind;
  } result_t;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;
  localparam int unsigned DIGIT_BITS = 4;

  // bit 4: byte is a hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      v  = b - CHAR_0;
      ok = 1'b1;
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      v  = b - CHAR_UA + HEX_TEN;
      ok = 1'b1;
    end else if (b >= CHAR_LA && b <= CHAR_LF_HEX) begin
      v  = b - CHAR_LA + HEX_TEN;
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

// ----- design/hcbd_in_if.sv -----
// Input channel of the chunked body decoder: one body byte per transaction.
// No dependencies.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       body_last;

  modport source (output valid, in_byte, body_last, input ready);
  modport sink (input valid, in_byte, body_last, output ready);
endinterface

// ----- design/hcbd_out_if.sv -----
// Output channel of the chunked body decoder: one decoded result per transaction.
// No dependencies.
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       carries_data;
  logic       body_end;
  logic       end_kind;

  modport source (output valid, out_byte, carries_data, body_end, end_kind, input ready);
  modport sink (input valid, out_byte, carries_data, body_end, end_kind, output ready);
endinterface

// ----- design/hcbd_step.sv -----
// Per-byte decode step: next phase, chunk count and result for one body byte.
// Depends on hcbd_pkg.
module hcbd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  hcbd_pkg::state_t        state_i,
  input  logic [SIZE_BITS-1:0]    count_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  output hcbd_pkg::state_t        state_o,
  output logic [SIZE_BITS-1:0]    count_o,
  output hcbd_pkg::result_t       res_o,
  output logic                    has_o
);

  localparam int unsigned DB = hcbd_pkg::DIGIT_BITS;

  logic [4:0]             hex;
  hcbd_pkg::phase_e       ph_work;
  logic [SIZE_BITS-1:0]   cnt_work;
  logic [SIZE_BITS-1:0]   size_base;
  logic [SIZE_BITS-1:0]   pass_base;
  logic                   do_size;
  logic                   do_pass;
  logic                   zero_end;
  logic                   end_now;

  assign hex = hcbd_pkg::hex_digit(byte_i);

  always_comb begin
    ph_work   = state_i.phase;
    cnt_work  = count_i;
    size_base = count_i;
    pass_base = count_i;
    do_size   = 1'b0;
    do_pass   = 1'b0;
    zero_end  = 1'b0;
    case (state_i.phase)
      hcbd_pkg::PH_SIZE_CR: begin
        if (byte_i == hcbd_pkg::CHAR_LF) ph_work = hcbd_pkg::PH_DATA;
        else do_pass = 1'b1;
      end
      hcbd_pkg::PH_DATA: begin
        do_pass = 1'b1;
      end
      hcbd_pkg::PH_TAIL: begin
        if (byte_i == hcbd_pkg::CHAR_CR) begin
          ph_work = hcbd_pkg::PH_TAIL_CR;
        end else begin
          ph_work   = hcbd_pkg::PH_SIZE;
          cnt_work  = '0;
          size_base = '0;
          do_size   = (byte_i != hcbd_pkg::CHAR_LF);
        end
      end
      hcbd_pkg::PH_TAIL_CR: begin
        ph_work   = hcbd_pkg::PH_SIZE;
        cnt_work  = '0;
        size_base = '0;
        do_size   = (byte_i != hcbd_pkg::CHAR_LF);
      end
      default: begin
        ph_work = hcbd_pkg::PH_SIZE;
        do_size = 1'b1;
      end
    endcase
    if (do_size) begin
      if (hex[4]) begin
        if (|size_base[SIZE_BITS-1:SIZE_BITS-DB]) cnt_work = '1;
        else cnt_work = {size_base[SIZE_BITS-DB-1:0], hex[3:0]};
      end else if (size_base == '0) begin
        zero_end = 1'b1;
      end else if (byte_i == hcbd_pkg::CHAR_CR) begin
        ph_work = hcbd_pkg::PH_SIZE_CR;
      end else if (byte_i == hcbd_pkg::CHAR_LF) begin
        ph_work = hcbd_pkg::PH_DATA;
      end else begin
        do_pass   = 1'b1;
        pass_base = size_base;
      end
    end
    if (do_pass) begin
      cnt_work = pass_base - {{(SIZE_BITS-1){1'b0}}, 1'b1};
      ph_work  = (cnt_work == '0) ? hcbd_pkg::PH_TAIL : hcbd_pkg::PH_DATA;
    end
  end

  assign end_now = zero_end || last_i;

  always_comb begin
    state_o = state_i;
    count_o = count_i;
    if (state_i.done) begin
      if (last_i) begin
        state_o.phase = hcbd_pkg::PH_SIZE;
        state_o.done  = 1'b0;
        count_o       = '0;
      end
    end else if (last_i) begin
      state_o.phase = hcbd_pkg::PH_SIZE;
      state_o.done  = 1'b0;
      count_o       = '0;
    end else begin
      state_o.phase = ph_work;
      state_o.done  = end_now;
      count_o       = cnt_work;
    end
  end

  always_comb begin
    res_o.carries_data = !state_i.done && do_pass;
    res_o.out_byte     = res_o.carries_data ? byte_i : 8'd0;
    res_o.body_end     = !state_i.done && end_now;
    res_o.end_kind     = !state_i.done && !zero_end && last_i && (cnt_work != '0);
    has_o              = res_o.carries_data || res_o.body_end;
  end

endmodule

// ----- design/http_chunked_body_decoder_core.sv -----
// Chunked body decoder: takes one body byte per cycle while the output is not stalled
// and gives at most one result per byte (a payload byte, an end of body, or both),
// registered in the input register and then in the result register. Throughput is one
// byte per cycle, set by the single decode step between those registers, while the output
// is not stalled; a stalled output holds the input register and then the input channel.
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbd_in_if.sink           in_i,
  hcbd_out_if.source        out_o
);

  logic                    in_valid_q;
  logic [7:0]              in_byte_q;
  logic                    in_last_q;
  logic                    out_valid_q;
  hcbd_pkg::result_t       out_res_q;
  hcbd_pkg::state_t        state_q;
  hcbd_pkg::state_t        state_d;
  logic [SIZE_BITS-1:0]    count_q;
  logic [SIZE_BITS-1:0]    count_d;
  hcbd_pkg::result_t       step_res;
  logic                    step_has;
  logic                    advance;
  logic                    fire;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  hcbd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .state_i (state_q),
    .count_i (count_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .count_o (count_d),
    .res_o   (step_res),
    .has_o   (step_has)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.phase <= hcbd_pkg::PH_SIZE;
      state_q.done  <= 1'b0;
      count_q       <= '0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) out_valid_q <= fire && step_has;
      if (fire) begin
        state_q <= state_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.body_last;
    end
    if (fire && step_has && advance) out_res_q <= step_res;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_res_q.out_byte;
  assign out_o.carries_data = out_res_q.carries_data;
  assign out_o.body_end     = out_res_q.body_end;
  assign out_o.end_kind     = out_res_q.end_kind;

  `HCBD_ASSERT_IMP(a_result_nonempty, out_valid_q, out_res_q.carries_data || out_res_q.body_end)
  `HCBD_ASSERT_IMP(a_kind_needs_end, out_valid_q && out_res_q.end_kind, out_res_q.body_end)
  `HCBD_ASSERT_IMP(a_idle_byte_zero, out_valid_q && !out_res_q.carries_data, out_res_q.out_byte == 8'd0)
  `HCBD_ASSERT_NXT(a_last_rearms, fire && in_last_q, !state_q.done && count_q == '0 && state_q.phase == hcbd_pkg::PH_SIZE)

endmodule
